FILE: rtl/core/task_ready_delay_queues_assert.svh
// Assertion macros for the task queue RTL.
`ifndef TASK_READY_DELAY_QUEUES_ASSERT_SVH
`define TASK_READY_DELAY_QUEUES_ASSERT_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define TRDQ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define TRDQ_ASSERT(label, prop, msg) \
  `TRDQ_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/core/trdq_pkg.sv
// Package with the constants and types of the task ready and delay queues.
package trdq_pkg;

  localparam int TaskSlots = 16;
  localparam int SlotW = 4;
  localparam int IdxW = $clog2(TaskSlots);
  localparam int CntW = $clog2(TaskSlots + 1);
  localparam int PrioW = 8;
  localparam int TimeW = 32;
  localparam int ReadyW = SlotW + PrioW;
  localparam int DelayW = SlotW + TimeW;

  localparam logic [SlotW-1:0] IdleSlot = SlotW'(0);
  localparam logic [PrioW-1:0] IdlePrio = PrioW'(127);

  typedef enum logic [1:0] {
    CmdReady = 2'd0,
    CmdDelay = 2'd1,
    CmdPause = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StPaused  = 2'd0,
    StReady   = 2'd1,
    StDelayed = 2'd2
  } slot_state_e;

  typedef enum logic [2:0] {
    SInit,
    SIdle,
    SPass,
    SPassEnd,
    SHead,
    SResp
  } fsm_e;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] key;
  } entry_t;

endpackage

FILE: rtl/core/trdq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module trdq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/task_ready_delay_queues.sv
// Top level of the task ready and delay queues with their walking sequencer.
// A command is taken when start_i is high and busy_o is low. The ready queue
// (sorted by signed priority) and the delay queue (sorted by wake time) sit in
// two RAMs, and a command walks the queue that holds the task and the queue
// it goes to, reading one entry per cycle and writing the reordered list back
// behind the read pointer. After its walks a command passes SHead and SResp
// with busy_o still high; the result is registered in SResp and appears once
// busy_o is low again. A new item can be taken in the cycle of the result.
// The result is shown for one cycle with done_o high and cannot be held
// off. After reset the block is busy for one cycle while the idle task is
// written into the ready queue.
`include "task_ready_delay_queues_assert.svh"

module task_ready_delay_queues
  import trdq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       cmd_i,
  input  logic [SlotW-1:0] task_slot_i,
  input  logic [PrioW-1:0] task_priority_i,
  input  logic [TimeW-1:0] wake_time_i,
  output logic             done_o,
  output logic             error_code_o,
  output logic [SlotW-1:0] ready_head_slot_o,
  output logic             delay_head_valid_o,
  output logic [SlotW-1:0] delay_head_slot_o,
  output logic [TimeW-1:0] delay_head_time_o,
  output logic [1:0]       slot_state_o
);

  fsm_e        state_q, state_d;
  slot_state_e slot_st_q [TaskSlots];

  cmd_e             cmd_q;
  logic [SlotW-1:0] slot_q;
  logic [PrioW-1:0] prio_q;
  logic [TimeW-1:0] time_q;
  logic             need_d_q;
  logic             sel_q, sel_d;
  logic             err_q;
  slot_state_e      res_st_q;

  logic [CntW-1:0] ready_cnt_q, delay_cnt_q;
  logic [CntW-1:0] c_q, c_d, w_q, w_d;
  logic            ins_q, ins_d, cv_q, cv_d, rem_q, rem_d;
  entry_t          carry_q, carry_d;

  logic        accept;
  cmd_e        cmd_in;
  logic        slot_ok, is_idle, act, err_in, need_r, need_d;
  slot_state_e old_st, new_st, res_st;

  logic [ReadyW-1:0] r_rdata, r_wdata;
  logic [DelayW-1:0] d_rdata;
  logic              r_we, d_we;
  logic [IdxW-1:0]   r_waddr, raddr;

  logic [CntW-1:0] pcnt, cnt_new;
  logic            do_ins, new_le, wr_en;
  entry_t          ent, nent, wr_ent;

  logic             done_q;
  logic             err_out_q;
  logic [SlotW-1:0] rhead_q, dhead_slot_q;
  logic             dhead_valid_q;
  logic [TimeW-1:0] dhead_time_q;
  logic [1:0]       st_out_q;

  assign accept = start_i && !busy_o;
  assign cmd_in = cmd_e'(cmd_i);
  assign slot_ok = 32'(task_slot_i) < TaskSlots;
  assign is_idle = task_slot_i == IdleSlot;
  assign old_st = slot_st_q[task_slot_i];

  always_comb begin
    act = 1'b0;
    err_in = 1'b0;
    new_st = old_st;
    unique case (cmd_in)
      CmdReady: begin
        act = slot_ok;
        new_st = StReady;
      end
      CmdDelay: begin
        act = slot_ok && !is_idle;
        err_in = slot_ok && is_idle;
        new_st = StDelayed;
      end
      CmdPause: begin
        act = slot_ok && !is_idle;
        err_in = slot_ok && is_idle;
        new_st = StPaused;
      end
      CmdNone: begin
        act = 1'b0;
      end
    endcase
    need_r = act && (cmd_in == CmdReady || old_st == StReady);
    need_d = act && (cmd_in == CmdDelay || old_st == StDelayed);
    if (!slot_ok) begin
      res_st = StPaused;
    end else if (act) begin
      res_st = new_st;
    end else begin
      res_st = old_st;
    end
  end

  assign pcnt = sel_q ? delay_cnt_q : ready_cnt_q;
  assign do_ins = sel_q ? (cmd_q == CmdDelay) : (cmd_q == CmdReady);

  always_comb begin
    if (sel_q) begin
      ent.slot = d_rdata[DelayW-1:TimeW];
      ent.key = d_rdata[TimeW-1:0];
      nent.slot = slot_q;
      nent.key = time_q;
      new_le = nent.key <= ent.key;
    end else begin
      ent.slot = r_rdata[ReadyW-1:PrioW];
      ent.key = {{(TimeW-PrioW){r_rdata[PrioW-1]}}, r_rdata[PrioW-1:0]};
      nent.slot = slot_q;
      nent.key = {{(TimeW-PrioW){prio_q[PrioW-1]}}, prio_q};
      new_le = $signed(nent.key) <= $signed(ent.key);
    end
  end

  always_comb begin
    c_d = c_q;
    w_d = w_q;
    ins_d = ins_q;
    cv_d = cv_q;
    rem_d = rem_q;
    carry_d = carry_q;
    wr_en = 1'b0;
    wr_ent = ent;
    if (state_q == SPass) begin
      c_d = c_q + CntW'(1);
      if (c_q != '0) begin
        if (ent.slot == slot_q) begin
          rem_d = 1'b1;
          if (cv_q) begin
            wr_en = 1'b1;
            wr_ent = carry_q;
            cv_d = 1'b0;
          end
        end else if (do_ins && !ins_q && new_le) begin
          wr_en = 1'b1;
          wr_ent = nent;
          carry_d = ent;
          cv_d = 1'b1;
          ins_d = 1'b1;
        end else if (cv_q) begin
          wr_en = 1'b1;
          wr_ent = carry_q;
          carry_d = ent;
        end else begin
          wr_en = 1'b1;
          wr_ent = ent;
        end
      end
      if (wr_en) begin
        w_d = w_q + CntW'(1);
      end
    end else begin
      if (state_q == SPassEnd) begin
        if (do_ins && !ins_q) begin
          wr_en = 1'b1;
          wr_ent = nent;
        end else if (cv_q) begin
          wr_en = 1'b1;
          wr_ent = carry_q;
        end
      end
      c_d = '0;
      w_d = '0;
      ins_d = 1'b0;
      cv_d = 1'b0;
      rem_d = 1'b0;
    end
  end

  assign cnt_new = pcnt - CntW'(rem_q) + CntW'(do_ins);

  always_comb begin
    state_d = state_q;
    sel_d = sel_q;
    unique case (state_q)
      SInit: state_d = SIdle;
      SIdle: begin
        if (start_i) begin
          sel_d = !need_r;
          if (need_r || need_d) begin
            state_d = SPass;
          end else begin
            state_d = SHead;
          end
        end
      end
      SPass: begin
        if (c_q == pcnt) begin
          state_d = SPassEnd;
        end
      end
      SPassEnd: begin
        if (!sel_q && need_d_q) begin
          sel_d = 1'b1;
          state_d = SPass;
        end else begin
          state_d = SHead;
        end
      end
      SHead: state_d = SResp;
      SResp: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    busy_o = state_q != SIdle;
    raddr = (state_q == SPass) ? c_q[IdxW-1:0] : '0;
    if (state_q == SInit) begin
      r_we = 1'b1;
      r_waddr = '0;
      r_wdata = {IdleSlot, IdlePrio};
    end else begin
      r_we = wr_en && !sel_q;
      r_waddr = w_q[IdxW-1:0];
      r_wdata = {wr_ent.slot, wr_ent.key[PrioW-1:0]};
    end
    d_we = wr_en && sel_q;
  end

  trdq_ram #(
    .Width(ReadyW),
    .Depth(TaskSlots)
  ) u_ready_ram (
    .clk_i  (clk_i),
    .we_i   (r_we),
    .waddr_i(r_waddr),
    .wdata_i(r_wdata),
    .raddr_i(raddr),
    .rdata_o(r_rdata)
  );

  trdq_ram #(
    .Width(DelayW),
    .Depth(TaskSlots)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(w_q[IdxW-1:0]),
    .wdata_i({wr_ent.slot, wr_ent.key}),
    .raddr_i(raddr),
    .rdata_o(d_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      sel_q <= 1'b0;
      ready_cnt_q <= CntW'(1);
      delay_cnt_q <= '0;
      c_q <= '0;
      w_q <= '0;
      ins_q <= 1'b0;
      cv_q <= 1'b0;
      rem_q <= 1'b0;
      done_q <= 1'b0;
      for (int i = 0; i < TaskSlots; i++) begin
        slot_st_q[i] <= (i == int'(IdleSlot)) ? StReady : StPaused;
      end
    end else begin
      state_q <= state_d;
      sel_q <= sel_d;
      c_q <= c_d;
      w_q <= w_d;
      ins_q <= ins_d;
      cv_q <= cv_d;
      rem_q <= rem_d;
      done_q <= state_q == SResp;
      if (accept && slot_ok) begin
        slot_st_q[task_slot_i] <= res_st;
      end
      if (state_q == SPassEnd) begin
        if (sel_q) begin
          delay_cnt_q <= cnt_new;
        end else begin
          ready_cnt_q <= cnt_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (accept) begin
      cmd_q <= cmd_in;
      slot_q <= task_slot_i;
      prio_q <= task_priority_i;
      time_q <= wake_time_i;
      need_d_q <= need_d;
      err_q <= err_in;
      res_st_q <= res_st;
    end
    if (state_q == SResp) begin
      err_out_q <= err_q;
      rhead_q <= (ready_cnt_q != '0) ? r_rdata[ReadyW-1:PrioW] : IdleSlot;
      dhead_valid_q <= delay_cnt_q != '0;
      dhead_slot_q <= (delay_cnt_q != '0) ? d_rdata[DelayW-1:TimeW] : '0;
      dhead_time_q <= (delay_cnt_q != '0) ? d_rdata[TimeW-1:0] : '0;
      st_out_q <= res_st_q;
    end
  end

  assign done_o = done_q;
  assign error_code_o = err_out_q;
  assign ready_head_slot_o = rhead_q;
  assign delay_head_valid_o = dhead_valid_q;
  assign delay_head_slot_o = dhead_slot_q;
  assign delay_head_time_o = dhead_time_q;
  assign slot_state_o = st_out_q;

  `TRDQ_ASSERT(a_ready_nonempty, ready_cnt_q != '0, "ready queue became empty")
  `TRDQ_ASSERT(a_count_bound,
               (state_q == SIdle) |-> (6'(ready_cnt_q) + 6'(delay_cnt_q)) <= 6'(TaskSlots),
               "queues hold more entries than task slots")
  `TRDQ_ASSERT(a_idle_ready, slot_st_q[IdleSlot] == StReady, "idle task left ready state")
  `TRDQ_ASSERT(a_accept_busy, accept |=> busy_o, "block not busy after taking an item")
  `TRDQ_ASSERT(a_write_bound, wr_en |-> (w_q < CntW'(TaskSlots)),
               "queue write beyond the last entry")

endmodule

FILE: tb/task_queue_checker.sv
// Checker that predicts and compares every result of the task ready and delay queues.
`timescale 1ns / 1ps

module task_queue_checker
  import trdq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [1:0]       cmd_i,
  input  logic [SlotW-1:0] task_slot_i,
  input  logic [PrioW-1:0] task_priority_i,
  input  logic [TimeW-1:0] wake_time_i,
  input  logic             done_i,
  input  logic             error_code_i,
  input  logic [SlotW-1:0] ready_head_slot_i,
  input  logic             delay_head_valid_i,
  input  logic [SlotW-1:0] delay_head_slot_i,
  input  logic [TimeW-1:0] delay_head_time_i,
  input  logic [1:0]       slot_state_i,
  output int               accepted_o,
  output int               pending_o,
  output int               failures_o
);

  typedef struct packed {
    logic             err;
    logic [SlotW-1:0] ready_head;
    logic             delay_valid;
    logic [SlotW-1:0] delay_slot;
    logic [TimeW-1:0] delay_time;
    logic [1:0]       state;
  } sched_result_t;

  logic        [SlotW-1:0] rdy_slot [TaskSlots];
  logic signed [PrioW-1:0] rdy_prio [TaskSlots];
  int                      rdy_n;
  logic        [SlotW-1:0] dly_slot [TaskSlots];
  logic        [TimeW-1:0] dly_time [TaskSlots];
  int                      dly_n;
  slot_state_e             slot_st  [TaskSlots];

  sched_result_t expected_q [$];
  int n_accepted = 0;
  int n_pending  = 0;
  int n_failed   = 0;

  assign accepted_o = n_accepted;
  assign pending_o  = n_pending;
  assign failures_o = n_failed;

  task automatic clear_model();
    int i;
    for (i = 0; i < TaskSlots; i++) begin
      rdy_slot[i] = '0;
      rdy_prio[i] = '0;
      dly_slot[i] = '0;
      dly_time[i] = '0;
      slot_st[i]  = StPaused;
    end
    rdy_slot[0] = IdleSlot;
    rdy_prio[0] = IdlePrio;
    rdy_n = 1;
    dly_n = 0;
    slot_st[IdleSlot] = StReady;
    expected_q.delete();
    n_accepted = 0;
    n_pending  = 0;
    n_failed   = 0;
  endtask

  task automatic drop_ready(input logic [SlotW-1:0] s);
    int i;
    int j;
    for (i = 0; i < rdy_n; i++) begin
      if (rdy_slot[i] == s) begin
        for (j = i; j < rdy_n - 1; j++) begin
          rdy_slot[j] = rdy_slot[j+1];
          rdy_prio[j] = rdy_prio[j+1];
        end
        rdy_n--;
        return;
      end
    end
  endtask

  task automatic drop_delay(input logic [SlotW-1:0] s);
    int i;
    int j;
    for (i = 0; i < dly_n; i++) begin
      if (dly_slot[i] == s) begin
        for (j = i; j < dly_n - 1; j++) begin
          dly_slot[j] = dly_slot[j+1];
          dly_time[j] = dly_time[j+1];
        end
        dly_n--;
        return;
      end
    end
  endtask

  // A new entry goes ahead of any entry with an equal key.
  task automatic add_ready(input logic [SlotW-1:0] s, input logic signed [PrioW-1:0] p);
    int pos;
    int j;
    pos = 0;
    if (rdy_n >= TaskSlots) return;
    while (pos < rdy_n && p > rdy_prio[pos]) pos++;
    for (j = rdy_n; j > pos; j--) begin
      rdy_slot[j] = rdy_slot[j-1];
      rdy_prio[j] = rdy_prio[j-1];
    end
    rdy_slot[pos] = s;
    rdy_prio[pos] = p;
    rdy_n++;
  endtask

  task automatic add_delay(input logic [SlotW-1:0] s, input logic [TimeW-1:0] t);
    int pos;
    int j;
    pos = 0;
    if (dly_n >= TaskSlots) return;
    while (pos < dly_n && t > dly_time[pos]) pos++;
    for (j = dly_n; j > pos; j--) begin
      dly_slot[j] = dly_slot[j-1];
      dly_time[j] = dly_time[j-1];
    end
    dly_slot[pos] = s;
    dly_time[pos] = t;
    dly_n++;
  endtask

  task automatic unlink(input logic [SlotW-1:0] s);
    if (slot_st[s] == StReady) begin
      drop_ready(s);
    end else if (slot_st[s] == StDelayed) begin
      drop_delay(s);
    end
    slot_st[s] = StPaused;
  endtask

  task automatic apply_command(input cmd_e c, input logic [SlotW-1:0] s,
                               input logic signed [PrioW-1:0] p,
                               input logic [TimeW-1:0] t, output sched_result_t r);
    r = '0;
    case (c)
      CmdReady: begin
        unlink(s);
        add_ready(s, p);
        slot_st[s] = StReady;
      end
      CmdDelay, CmdPause: begin
        // The idle task must never leave the ready queue.
        if (s == IdleSlot) begin
          r.err = 1'b1;
        end else if (c == CmdDelay) begin
          unlink(s);
          add_delay(s, t);
          slot_st[s] = StDelayed;
        end else begin
          unlink(s);
        end
      end
      default: ;
    endcase
    r.state      = slot_st[s];
    r.ready_head = (rdy_n > 0) ? rdy_slot[0] : IdleSlot;
    if (dly_n > 0) begin
      r.delay_valid = 1'b1;
      r.delay_slot  = dly_slot[0];
      r.delay_time  = dly_time[0];
    end
  endtask

  function automatic string show(input sched_result_t r);
    return $sformatf("err=%0d ready_head=%0d delay_valid=%0d delay_slot=%0d delay_time=%h state=%0d",
                     r.err, r.ready_head, r.delay_valid, r.delay_slot, r.delay_time, r.state);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    sched_result_t got;
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (done_i) begin
        got.err         = error_code_i;
        got.ready_head  = ready_head_slot_i;
        got.delay_valid = delay_head_valid_i;
        got.delay_slot  = delay_head_slot_i;
        got.delay_time  = delay_head_time_i;
        got.state       = slot_state_i;
        if (expected_q.size() == 0) begin
          n_failed++;
          if (n_failed <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = expected_q.pop_front();
          if (got.err !== want.err || got.ready_head !== want.ready_head ||
              got.delay_valid !== want.delay_valid || got.delay_slot !== want.delay_slot ||
              got.delay_time !== want.delay_time || got.state !== want.state) begin
            n_failed++;
            if (n_failed <= 10) begin
              $display("mismatch: expected %s", show(want));
              $display("          actual   %s", show(got));
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        apply_command(cmd_e'(cmd_i), task_slot_i, task_priority_i, wake_time_i, want);
        expected_q.push_back(want);
        n_accepted++;
      end
      n_pending = expected_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Top of the testbench: clock, reset, command stimulus and the verdict.
`timescale 1ns / 1ps

module tb_top;
  import trdq_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [1:0]       cmd_i;
  logic [SlotW-1:0] task_slot_i;
  logic [PrioW-1:0] task_priority_i;
  logic [TimeW-1:0] wake_time_i;
  logic             done_o;
  logic             error_code_o;
  logic [SlotW-1:0] ready_head_slot_o;
  logic             delay_head_valid_o;
  logic [SlotW-1:0] delay_head_slot_o;
  logic [TimeW-1:0] delay_head_time_o;
  logic [1:0]       slot_state_o;

  int accepted;
  int pending;
  int failures;

  always #4 clk_i = ~clk_i;

  task_ready_delay_queues uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .cmd_i              (cmd_i),
    .task_slot_i        (task_slot_i),
    .task_priority_i    (task_priority_i),
    .wake_time_i        (wake_time_i),
    .done_o             (done_o),
    .error_code_o       (error_code_o),
    .ready_head_slot_o  (ready_head_slot_o),
    .delay_head_valid_o (delay_head_valid_o),
    .delay_head_slot_o  (delay_head_slot_o),
    .delay_head_time_o  (delay_head_time_o),
    .slot_state_o       (slot_state_o)
  );

  task_queue_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_i             (busy_o),
    .cmd_i              (cmd_i),
    .task_slot_i        (task_slot_i),
    .task_priority_i    (task_priority_i),
    .wake_time_i        (wake_time_i),
    .done_i             (done_o),
    .error_code_i       (error_code_o),
    .ready_head_slot_i  (ready_head_slot_o),
    .delay_head_valid_i (delay_head_valid_o),
    .delay_head_slot_i  (delay_head_slot_o),
    .delay_head_time_i  (delay_head_time_o),
    .slot_state_i       (slot_state_o),
    .accepted_o         (accepted),
    .pending_o          (pending),
    .failures_o         (failures)
  );

  // Called at a falling edge; returns at the falling edge after the item was taken.
  task automatic issue(input cmd_e c, input logic [SlotW-1:0] s,
                       input logic [PrioW-1:0] p, input logic [TimeW-1:0] t);
    int seen;
    seen = accepted;
    start_i         <= 1'b1;
    cmd_i           <= c;
    task_slot_i     <= s;
    task_priority_i <= p;
    wake_time_i     <= t;
    do @(negedge clk_i); while (accepted == seen);
  endtask

  task automatic idle_for(input int cycles);
    start_i         <= 1'b0;
    cmd_i           <= 2'($urandom);
    task_slot_i     <= SlotW'($urandom);
    task_priority_i <= PrioW'($urandom);
    wake_time_i     <= $urandom;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic maybe_idle(input int pct);
    if ($urandom_range(1, 100) <= pct) idle_for($urandom_range(1, 14));
  endtask

  function automatic logic [SlotW-1:0] pick_slot();
    if ($urandom_range(0, 7) == 0) return IdleSlot;
    return SlotW'($urandom_range(0, TaskSlots - 1));
  endfunction

  // Keys are often drawn from a few values so that equal keys are common.
  function automatic logic [PrioW-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0:       return PrioW'($urandom_range(0, 3)) - PrioW'(1);
      1:       return $urandom_range(0, 1) ? 8'h80 : 8'h7f;
      default: return PrioW'($urandom);
    endcase
  endfunction

  function automatic logic [TimeW-1:0] pick_time();
    case ($urandom_range(0, 3))
      0:       return TimeW'(100 + $urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    cmd_e c;
    int   pick;
    int   gap_pct;
    int   w_ready;
    int   w_delay;
    int   w_pause;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    cmd_i           = CmdNone;
    task_slot_i     = '0;
    task_priority_i = '0;
    wake_time_i     = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    issue(CmdPause, IdleSlot, 8'h00, 32'h0);
    issue(CmdDelay, IdleSlot, 8'h00, 32'h5);
    issue(CmdReady, IdleSlot, 8'h80, 32'h0);
    maybe_idle(50);
    issue(CmdReady, IdleSlot, 8'h7f, 32'h0);
    issue(CmdPause, 4'd5, 8'h00, 32'h0);
    issue(CmdNone, 4'd3, 8'h12, 32'h34);
    issue(CmdReady, 4'd1, 8'h80, 32'h0);
    maybe_idle(50);
    issue(CmdReady, 4'd2, 8'h7f, 32'h0);
    issue(CmdReady, 4'd3, 8'h80, 32'h0);
    issue(CmdDelay, 4'd4, 8'h00, 32'hffff_ffff);
    issue(CmdDelay, 4'd5, 8'h00, 32'h0);
    maybe_idle(50);
    issue(CmdDelay, 4'd6, 8'h00, 32'h0);
    issue(CmdDelay, 4'd7, 8'h00, 32'hffff_ffff);
    issue(CmdReady, 4'd6, 8'h00, 32'h0);
    issue(CmdDelay, 4'd3, 8'hff, 32'd1000);
    maybe_idle(50);
    issue(CmdReady, 4'd1, 8'd10, 32'h0);
    issue(CmdDelay, 4'd4, 8'h00, 32'd5);
    issue(CmdPause, 4'd5, 8'h00, 32'h0);
    issue(CmdPause, 4'd2, 8'h00, 32'h0);
    issue(CmdNone, 4'd15, 8'hff, 32'hffff_ffff);
    issue(CmdReady, 4'd15, 8'hff, 32'h0);
    issue(CmdDelay, 4'd15, 8'h00, 32'h8000_0000);
    issue(CmdPause, 4'd6, 8'h00, 32'h0);

    for (int ph = 0; ph < 6; ph++) begin
      gap_pct = (ph == 5) ? 0 : $urandom_range(0, 50);
      if (ph % 2 == 0) begin
        w_ready = 40;
        w_delay = 85;
        w_pause = 97;
      end else begin
        w_ready = 25;
        w_delay = 50;
        w_pause = 95;
      end
      for (int k = 0; k < 100; k++) begin
        maybe_idle(gap_pct);
        pick = $urandom_range(0, 99);
        if (pick < w_ready) begin
          c = CmdReady;
        end else if (pick < w_delay) begin
          c = CmdDelay;
        end else if (pick < w_pause) begin
          c = CmdPause;
        end else begin
          c = CmdNone;
        end
        issue(c, pick_slot(), pick_priority(), pick_time());
      end
    end
    start_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
